// File: src/nwrs_pkg.sv
// nwrs_pkg: shared types and codes for the nak window sender
// used by the controller, the datapath, the top level and the checker
package nwrs_pkg;

    localparam int CMD_W      = 3;
    localparam int LEN_IN_W   = 6;
    localparam int RETRY_W    = 8;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 2;

    localparam logic [RETRY_W-1:0] RETRY_MAX         = 8'd255;
    localparam logic [RETRY_W-1:0] RETRY_LIMIT_RESET = 8'd5;

    typedef enum logic [CMD_W-1:0] {
        CMD_OPEN    = 3'd0,
        CMD_SEND    = 3'd1,
        CMD_MISSING = 3'd2,
        CMD_REPORT  = 3'd3,
        CMD_TIMEOUT = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_FIN   = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_ABORT = 2'd3
    } kind_t;

    // controller to datapath
    typedef struct packed {
        logic  open;
        logic  scan_init;
        logic  scan_step;
        logic  missing;
        logic  clr_report;
        logic  timeout;
        logic  close;
        logic  emit;
        kind_t kind;
        logic  last;
    } dp_ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic closed;
        logic report_seen;
        logic scan_end;
        logic cur_sent;
        logic miss_abort;
        logic timeout_ends;
    } dp_stat_t;

endpackage

// File: src/nak_window_retransmit_sender.sv
// nak_window_retransmit_sender: top level, apb register and unit wiring
// depends on nwrs_pkg, nwrs_ctrl and nwrs_datapath
//
// A request is taken when start is high and busy is low. Open, missing entry
// and report end are handled in the idle state; a timeout that also ends
// the window goes on through the done state. A send pass walks the window's
// sent flags one per cycle, at most WINDOW of them, and then gives FIN, with
// busy held high for the whole pass, FIN included. Each result shows on kind,
// seq and last for exactly one cycle with strobe high, the cycle after the
// edge that produced it; the receiver cannot stall, so it must take every
// strobe. retry_limit sits at byte address 0 and should be written only
// while the block is idle.
module nak_window_retransmit_sender #(
    parameter int WINDOW   = 32,
    parameter int SEQ_BITS = 20
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [nwrs_pkg::CMD_W-1:0]       command,
    input  logic [SEQ_BITS-1:0]              window_start,
    input  logic [nwrs_pkg::LEN_IN_W-1:0]    window_length,
    input  logic [SEQ_BITS-1:0]              missing_seq,
    output logic                             strobe,
    output logic [1:0]                       kind,
    output logic [SEQ_BITS-1:0]              seq,
    output logic                             last,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [nwrs_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [nwrs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [nwrs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import nwrs_pkg::*;

    logic [RETRY_W-1:0] limit_reg, limit_next;
    logic               cfg_wr;
    dp_ctrl_t           ctl;
    dp_stat_t           stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // single word register, byte offset bits ignored on writes
    assign limit_next = cfg_wr ? pwdata[RETRY_W-1:0] : limit_reg;
    assign prdata     = (paddr == '0) ? APB_DATA_W'(limit_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= RETRY_LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    nwrs_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (stat),
        .ctl     (ctl),
        .busy    (busy)
    );

    nwrs_datapath #(
        .WINDOW   (WINDOW),
        .SEQ_BITS (SEQ_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .stat          (stat),
        .window_start  (window_start),
        .window_length (window_length),
        .missing_seq   (missing_seq),
        .retry_limit   (limit_reg),
        .strobe        (strobe),
        .kind          (kind),
        .seq           (seq),
        .last          (last)
    );

endmodule

// File: src/nwrs_datapath.sv
// nwrs_datapath: window state, sent flags, scan index and result registers
// depends on nwrs_pkg; driven by nwrs_ctrl
module nwrs_datapath #(
    parameter int WINDOW   = 32,
    parameter int SEQ_BITS = 20
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  nwrs_pkg::dp_ctrl_t             ctl,
    output nwrs_pkg::dp_stat_t             stat,
    input  logic [SEQ_BITS-1:0]            window_start,
    input  logic [nwrs_pkg::LEN_IN_W-1:0]  window_length,
    input  logic [SEQ_BITS-1:0]            missing_seq,
    input  logic [nwrs_pkg::RETRY_W-1:0]   retry_limit,
    output logic                           strobe,
    output logic [1:0]                     kind,
    output logic [SEQ_BITS-1:0]            seq,
    output logic                           last
);
    import nwrs_pkg::*;

    localparam int LW = $clog2(WINDOW + 1);
    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int EW = SEQ_BITS + 2;

    logic [WINDOW-1:0]   flags_reg, flags_next;
    logic [WINDOW-1:0]   mask_reg, mask_next;
    logic [SEQ_BITS-1:0] base_reg, base_next;
    logic [LW-1:0]       len_reg, len_next;
    logic [LW-1:0]       idx_reg, idx_next;
    logic [RETRY_W-1:0]  retry_reg, retry_next;
    logic                report_reg, report_next;
    logic                closed_reg, closed_next;

    logic                strobe_reg, strobe_next;
    logic [1:0]          kind_reg, kind_next;
    logic [SEQ_BITS-1:0] seq_reg, seq_next;
    logic                last_reg, last_next;

    logic [LW-1:0]       len_sat;
    logic [EW-1:0]       m_ext, base_ext, end_ext, lim_ext;
    logic                in_win;
    logic [IW-1:0]       off;
    logic [RETRY_W-1:0]  retry_inc;
    logic                all_sent;

    assign len_sat = ({1'b0, window_length} > (LEN_IN_W + 1)'(WINDOW))
                     ? LW'(WINDOW) : LW'(window_length);

    // window end and abort limit computed without wrap
    assign m_ext    = EW'(missing_seq);
    assign base_ext = EW'(base_reg);
    assign end_ext  = base_ext + EW'(len_reg);
    assign lim_ext  = end_ext + EW'(len_reg);
    assign in_win   = (m_ext >= base_ext) && (m_ext < end_ext);
    assign off      = IW'(missing_seq - base_reg);

    assign retry_inc = (retry_reg == RETRY_MAX) ? RETRY_MAX : retry_reg + 1'b1;
    assign all_sent  = &(flags_reg | ~mask_reg);

    always_comb
    begin
        stat.closed       = closed_reg;
        stat.report_seen  = report_reg;
        stat.scan_end     = (idx_reg >= len_reg);
        stat.cur_sent     = flags_reg[idx_reg[IW-1:0]];
        stat.miss_abort   = !in_win && (m_ext >= end_ext) && (m_ext < lim_ext);
        stat.timeout_ends = all_sent && (retry_inc > retry_limit);
    end

    always_comb
    begin
        flags_next  = flags_reg;
        mask_next   = mask_reg;
        base_next   = base_reg;
        len_next    = len_reg;
        idx_next    = idx_reg;
        retry_next  = retry_reg;
        report_next = report_reg;
        closed_next = closed_reg;

        if (ctl.open)
        begin
            base_next   = window_start;
            len_next    = len_sat;
            flags_next  = '0;
            retry_next  = '0;
            report_next = 1'b0;
            closed_next = 1'b0;
            for (int i = 0; i < WINDOW; i++)
            begin
                mask_next[i] = (LW'(i) < len_sat);
            end
        end
        if (ctl.scan_init)
        begin
            idx_next    = '0;
            report_next = 1'b0;
        end
        if (ctl.scan_step)
        begin
            flags_next[idx_reg[IW-1:0]] = 1'b1;
            idx_next = idx_reg + 1'b1;
        end
        if (ctl.missing)
        begin
            if (stat.miss_abort)
            begin
                closed_next = 1'b1;
            end
            else
            begin
                report_next = 1'b1;
                if (in_win)
                begin
                    flags_next[off] = 1'b0;
                end
            end
        end
        if (ctl.clr_report)
        begin
            retry_next  = '0;
            report_next = 1'b0;
        end
        if (ctl.timeout)
        begin
            retry_next = retry_inc;
        end
        if (ctl.close)
        begin
            closed_next = 1'b1;
        end
    end

    always_comb
    begin
        strobe_next = ctl.emit;
        kind_next   = ctl.kind;
        last_next   = ctl.last;
        seq_next    = '0;
        if (ctl.emit && ctl.kind == KIND_DATA)
        begin
            seq_next = base_reg + SEQ_BITS'(idx_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg  <= '0;
            mask_reg   <= '0;
            base_reg   <= '0;
            len_reg    <= '0;
            idx_reg    <= '0;
            retry_reg  <= '0;
            report_reg <= 1'b0;
            closed_reg <= 1'b1;
            strobe_reg <= 1'b0;
        end
        else
        begin
            flags_reg  <= flags_next;
            mask_reg   <= mask_next;
            base_reg   <= base_next;
            len_reg    <= len_next;
            idx_reg    <= idx_next;
            retry_reg  <= retry_next;
            report_reg <= report_next;
            closed_reg <= closed_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        seq_reg  <= seq_next;
        last_reg <= last_next;
    end

    assign strobe = strobe_reg;
    assign kind   = kind_reg;
    assign seq    = seq_reg;
    assign last   = last_reg;

endmodule

// File: src/nwrs_ctrl.sv
// nwrs_ctrl: command decode and send pass sequencing
// depends on nwrs_pkg; steers nwrs_datapath through dp_ctrl_t
module nwrs_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [nwrs_pkg::CMD_W-1:0]    command,
    input  nwrs_pkg::dp_stat_t            stat,
    output nwrs_pkg::dp_ctrl_t            ctl,
    output logic                          busy
);
    import nwrs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    cmd_t   cmd;

    assign cmd  = cmd_t'(command);
    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        ctl        = '0;
        ctl.kind   = KIND_DATA;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd)
                        CMD_OPEN:
                        begin
                            ctl.open = 1'b1;
                        end
                        CMD_SEND:
                        begin
                            if (!stat.closed)
                            begin
                                ctl.scan_init = 1'b1;
                                state_next    = ST_SCAN;
                            end
                        end
                        CMD_MISSING:
                        begin
                            if (!stat.closed)
                            begin
                                ctl.missing = 1'b1;
                                if (stat.miss_abort)
                                begin
                                    ctl.emit = 1'b1;
                                    ctl.kind = KIND_ABORT;
                                    ctl.last = 1'b1;
                                end
                            end
                        end
                        CMD_REPORT:
                        begin
                            if (!stat.closed)
                            begin
                                // empty report ends the window
                                if (!stat.report_seen)
                                begin
                                    ctl.emit  = 1'b1;
                                    ctl.kind  = KIND_DONE;
                                    ctl.last  = 1'b1;
                                    ctl.close = 1'b1;
                                end
                                else
                                begin
                                    ctl.clr_report = 1'b1;
                                end
                            end
                        end
                        CMD_TIMEOUT:
                        begin
                            if (!stat.closed)
                            begin
                                ctl.timeout = 1'b1;
                                ctl.emit    = 1'b1;
                                ctl.kind    = KIND_FIN;
                                ctl.last    = !stat.timeout_ends;
                                if (stat.timeout_ends)
                                begin
                                    state_next = ST_DONE;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (!stat.scan_end)
                begin
                    ctl.scan_step = 1'b1;
                    ctl.emit      = !stat.cur_sent;
                end
                else
                begin
                    ctl.emit   = 1'b1;
                    ctl.kind   = KIND_FIN;
                    ctl.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DONE:
            begin
                ctl.emit   = 1'b1;
                ctl.kind   = KIND_DONE;
                ctl.last   = 1'b1;
                ctl.close  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: src/nwrs_checker.sv
// nwrs_checker: port level checks on the nak window sender
// depends on nwrs_pkg; bound to nak_window_retransmit_sender below
module nwrs_checker #(
    parameter int SEQ_BITS = 20
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [nwrs_pkg::CMD_W-1:0]    command,
    input logic                          strobe,
    input logic [1:0]                    kind,
    input logic [SEQ_BITS-1:0]           seq,
    input logic                          last
);
    import nwrs_pkg::*;

    // the last result of a request always coincides with the block going idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (last == !busy))
        else $error("last flag disagrees with busy");

    a_seq_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && kind != KIND_DATA) |-> (seq == '0))
        else $error("non-data result carries a sequence number");

    a_data_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && kind == KIND_DATA) |-> !last)
        else $error("data result marked last");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (kind == KIND_DONE || kind == KIND_ABORT)) |-> last)
        else $error("done or abort not marked last");

    a_open_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == CMD_OPEN) |=> !strobe)
        else $error("open request produced a result");

endmodule

bind nak_window_retransmit_sender nwrs_checker #(
    .SEQ_BITS (SEQ_BITS)
) u_nwrs_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .command (command),
    .strobe  (strobe),
    .kind    (kind),
    .seq     (seq),
    .last    (last)
);

// File: bench/tb_nak_window_retransmit_sender.sv
// tb_nak_window_retransmit_sender: self-checking bench for the nak window sender
// drives a directed table and then random window sessions, checks every emit
// depends on nwrs_pkg and nak_window_retransmit_sender
`timescale 1ns / 100ps

module tb_nak_window_retransmit_sender;
    import nwrs_pkg::*;

    localparam int WINDOW      = 32;
    localparam int SEQ_BITS    = 20;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = WINDOW + 8;

    localparam logic [SEQ_BITS-1:0]   SEQ_MAX          = '1;
    localparam logic [CMD_W-1:0]      CMD_UNUSED_LO    = 3'd5;
    localparam logic [CMD_W-1:0]      CMD_UNUSED_HI    = 3'd7;
    localparam logic [APB_ADDR_W-1:0] RETRY_LIMIT_ADDR = '0;

    typedef struct {
        kind_t               kind;
        logic [SEQ_BITS-1:0] seq;
        logic                last;
    } emit_t;

    typedef struct {
        logic [CMD_W-1:0]    cmd;
        logic [SEQ_BITS-1:0] ws;
        logic [LEN_IN_W-1:0] wl;
        logic [SEQ_BITS-1:0] ms;
        bit                  typed;
        int                  n_emits;
        kind_t               k0;
        kind_t               k1;
    } row_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [CMD_W-1:0]      command = '0;
    logic [SEQ_BITS-1:0]   window_start = '0;
    logic [LEN_IN_W-1:0]   window_length = '0;
    logic [SEQ_BITS-1:0]   missing_seq = '0;
    logic                  strobe;
    logic [1:0]            kind;
    logic [SEQ_BITS-1:0]   seq;
    logic                  last;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // shadow of the sender window
    logic [WINDOW-1:0]     sent_map;
    logic [SEQ_BITS-1:0]   win_base;
    int                    win_len;
    int                    retry_cnt;
    bit                    nak_seen;
    bit                    win_closed;
    int                    retry_limit_now;

    emit_t                 expected_emits[$];
    row_t                  steps[$];
    int                    mismatch_count = 0;
    int                    live_requests = 0;
    int                    idle_pct = 0;

    nak_window_retransmit_sender #(
        .WINDOW   (WINDOW),
        .SEQ_BITS (SEQ_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .window_start  (window_start),
        .window_length (window_length),
        .missing_seq   (missing_seq),
        .strobe        (strobe),
        .kind          (kind),
        .seq           (seq),
        .last          (last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb_nak_window_retransmit_sender: errors");
        $finish;
    end

    function automatic emit_t make_emit(input kind_t k, input logic [SEQ_BITS-1:0] s);
        emit_t e;
        e.kind = k;
        e.seq  = s;
        e.last = 1'b0;
        return e;
    endfunction

    function automatic logic [SEQ_BITS-1:0] rand_seq();
        return SEQ_BITS'($urandom);
    endfunction

    function automatic logic [LEN_IN_W-1:0] rand_len();
        return LEN_IN_W'($urandom);
    endfunction

    task automatic sender_predict(input logic [CMD_W-1:0] c, input logic [SEQ_BITS-1:0] ws,
                                  input logic [LEN_IN_W-1:0] wl,
                                  input logic [SEQ_BITS-1:0] ms, input bit keep);
        emit_t  outs[$];
        longint lo;
        longint hi;
        longint m;
        bit     all_set;
        if (c == CMD_OPEN)
        begin
            live_requests++;
            win_base   = ws;
            win_len    = (wl > WINDOW) ? WINDOW : wl;
            sent_map   = '0;
            retry_cnt  = 0;
            nak_seen   = 1'b0;
            win_closed = 1'b0;
        end
        else if (!win_closed && c <= CMD_TIMEOUT)
        begin
            live_requests++;
            case (c)
                CMD_SEND:
                begin
                    for (int i = 0; i < win_len; i++)
                    begin
                        if (!sent_map[i])
                        begin
                            outs.insert(outs.size(),
                                        make_emit(KIND_DATA, win_base + SEQ_BITS'(i)));
                            sent_map[i] = 1'b1;
                        end
                    end
                    nak_seen = 1'b0;
                    outs.insert(outs.size(), make_emit(KIND_FIN, '0));
                end
                CMD_MISSING:
                begin
                    // window end is taken without wrap
                    m  = ms;
                    lo = win_base;
                    hi = lo + win_len;
                    if (m >= lo && m < hi)
                    begin
                        sent_map[m - lo] = 1'b0;
                        nak_seen = 1'b1;
                    end
                    else if (m >= hi && m < hi + win_len)
                    begin
                        outs.insert(outs.size(), make_emit(KIND_ABORT, '0));
                        win_closed = 1'b1;
                    end
                    else
                        nak_seen = 1'b1;
                end
                CMD_REPORT:
                begin
                    if (!nak_seen)
                    begin
                        outs.insert(outs.size(), make_emit(KIND_DONE, '0));
                        win_closed = 1'b1;
                    end
                    else
                    begin
                        retry_cnt = 0;
                        nak_seen  = 1'b0;
                    end
                end
                default:
                begin
                    if (retry_cnt < RETRY_MAX)
                        retry_cnt++;
                    outs.insert(outs.size(), make_emit(KIND_FIN, '0));
                    all_set = 1'b1;
                    for (int i = 0; i < win_len; i++)
                        if (!sent_map[i])
                            all_set = 1'b0;
                    if (all_set && retry_cnt > retry_limit_now)
                    begin
                        outs.insert(outs.size(), make_emit(KIND_DONE, '0));
                        win_closed = 1'b1;
                    end
                end
            endcase
        end
        if (outs.size() > 0)
            outs[outs.size() - 1].last = 1'b1;
        if (keep)
            foreach (outs[i])
                expected_emits.insert(expected_emits.size(), outs[i]);
    endtask

    // check each emit against the oldest expectation
    always @(posedge clk)
    begin
        emit_t want;
        if (rst_n && strobe)
        begin
            if (expected_emits.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected emit: expected none, got kind %0d seq %05h last %0b",
                         $time, kind, seq, last);
            end
            else
            begin
                want = expected_emits.pop_front();
                if (kind !== want.kind || seq !== want.seq || last !== want.last)
                begin
                    mismatch_count++;
                    $display({"%0t: emit mismatch: expected kind %0d seq %05h last %0b,",
                              " got kind %0d seq %05h last %0b"}, $time, want.kind,
                             want.seq, want.last, kind, seq, last);
                end
            end
        end
    end

    // random sender gaps, geometric in length
    task automatic sender_gap();
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic run_request(input logic [CMD_W-1:0] c, input logic [SEQ_BITS-1:0] ws,
                               input logic [LEN_IN_W-1:0] wl,
                               input logic [SEQ_BITS-1:0] ms, input bit keep);
        command       <= c;
        window_start  <= ws;
        window_length <= wl;
        missing_seq   <= ms;
        start         <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        sender_predict(c, ws, wl, ms, keep);
        sender_gap();
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_emits.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic apb_access(input bit wr, input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= RETRY_LIMIT_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_limit_reg(input int want);
        logic [APB_DATA_W-1:0] got;
        apb_access(1'b0, '0, got);
        if (got !== APB_DATA_W'(want))
        begin
            mismatch_count++;
            $display("%0t: retry_limit readback expected %0d got %0d", $time, want, got);
        end
    endtask

    task automatic set_retry_limit(input int value);
        logic [APB_DATA_W-1:0] unused;
        drain();
        apb_access(1'b1, APB_DATA_W'(value), unused);
        retry_limit_now = value;
        check_limit_reg(value);
    endtask

    task automatic add_row(input logic [CMD_W-1:0] c, input logic [SEQ_BITS-1:0] ws,
                           input logic [LEN_IN_W-1:0] wl, input logic [SEQ_BITS-1:0] ms,
                           input bit typed, input int n, input kind_t k0, input kind_t k1);
        row_t r;
        r.cmd = c;
        r.ws = ws;
        r.wl = wl;
        r.ms = ms;
        r.typed = typed;
        r.n_emits = n;
        r.k0 = k0;
        r.k1 = k1;
        steps.insert(steps.size(), r);
    endtask

    // mostly inside the window, some in the abort band, the rest anywhere
    function automatic logic [SEQ_BITS-1:0] pick_missing(input logic [SEQ_BITS-1:0] b,
                                                          input int len);
        int p;
        p = $urandom_range(99);
        if (len > 0 && p < 60)
            return b + SEQ_BITS'($urandom_range(len - 1));
        if (len > 0 && p < 75)
            return b + SEQ_BITS'(len + $urandom_range(len - 1));
        return SEQ_BITS'($urandom);
    endfunction

    task automatic maybe_noise();
        if ($urandom_range(9) == 0)
            run_request(CMD_W'($urandom_range(7)), rand_seq(), rand_len(), rand_seq(), 1'b1);
    endtask

    // open, send, a few nak rounds, then timeouts and possibly a final report
    task automatic run_session();
        logic [SEQ_BITS-1:0] b;
        logic [LEN_IN_W-1:0] l;
        int                  p;
        int                  eff_len;
        int                  tries;
        p = $urandom_range(99);
        if (p < 65)
            l = LEN_IN_W'($urandom_range(8, 1));
        else if (p < 80)
            l = LEN_IN_W'(WINDOW);
        else if (p < 90)
            l = '0;
        else
            l = LEN_IN_W'($urandom_range(63, WINDOW + 1));
        b = ($urandom_range(3) == 0) ? SEQ_MAX - SEQ_BITS'($urandom_range(40)) :
                                       SEQ_BITS'($urandom);
        eff_len = (l > WINDOW) ? WINDOW : l;
        run_request(CMD_OPEN, b, l, rand_seq(), 1'b1);
        run_request(CMD_SEND, rand_seq(), rand_len(), rand_seq(), 1'b1);
        repeat ($urandom_range(3, 1))
        begin
            repeat ($urandom_range(3))
            begin
                maybe_noise();
                run_request(CMD_MISSING, rand_seq(), rand_len(), pick_missing(b, eff_len),
                            1'b1);
            end
            run_request(CMD_REPORT, rand_seq(), rand_len(), rand_seq(), 1'b1);
            maybe_noise();
            run_request(CMD_SEND, rand_seq(), rand_len(), rand_seq(), 1'b1);
        end
        tries = (retry_limit_now <= 8) ? $urandom_range(retry_limit_now + 2) :
                                         $urandom_range(3);
        repeat (tries)
            run_request(CMD_TIMEOUT, rand_seq(), rand_len(), rand_seq(), 1'b1);
        if ($urandom_range(1))
            run_request(CMD_REPORT, rand_seq(), rand_len(), rand_seq(), 1'b1);
    endtask

    task automatic run_phase(input int limit, input int pct, input int target);
        int first;
        set_retry_limit(limit);
        idle_pct = pct;
        first = live_requests;
        while (live_requests - first < target)
            run_session();
    endtask

    initial
    begin
        emit_t typed_emit;

        sent_map        = '0;
        win_base        = '0;
        win_len         = 0;
        retry_cnt       = 0;
        nak_seen        = 1'b0;
        win_closed      = 1'b1;
        retry_limit_now = RETRY_LIMIT_RESET;

        // closed window and unused codes
        add_row(CMD_TIMEOUT,   '0,       6'd0,  '0,       1'b1, 0, KIND_DATA, KIND_DATA);
        add_row(CMD_SEND,      '0,       6'd0,  '0,       1'b1, 0, KIND_DATA, KIND_DATA);
        add_row(CMD_UNUSED_LO, SEQ_MAX,  6'd63, SEQ_MAX,  1'b1, 0, KIND_DATA, KIND_DATA);
        // window across the sequence wrap
        add_row(CMD_OPEN,      20'hFFFFE, 6'd4, '0,       1'b1, 0, KIND_DATA, KIND_DATA);
        add_row(CMD_SEND,      '0,       6'd0,  '0,       1'b0, 0, KIND_DATA, KIND_DATA);
        add_row(CMD_MISSING,   '0,       6'd0,  SEQ_MAX,  1'b1, 0, KIND_DATA, KIND_DATA);
        add_row(CMD_MISSING,   '0,       6'd0,  '0,       1'b1, 0, KIND_DATA, KIND_DATA);
        add_row(CMD_UNUSED_HI, SEQ_MAX,  6'd63, SEQ_MAX,  1'b1, 0, KIND_DATA, KIND_DATA);
        add_row(CMD_SEND,      '0,       6'd0,  '0,       1'b0, 0, KIND_DATA, KIND_DATA);
        add_row(CMD_MISSING,   '0,       6'd0,  20'hFFFFE, 1'b1, 0, KIND_DATA, KIND_DATA);
        add_row(CMD_REPORT,    '0,       6'd0,  '0,       1'b1, 0, KIND_DATA, KIND_DATA);
        // empty report ends the window
        add_row(CMD_REPORT,    '0,       6'd0,  '0,       1'b1, 1, KIND_DONE, KIND_DATA);
        // oversized length clamps to the full window
        add_row(CMD_OPEN,      20'd100,  6'd63, '0,       1'b1, 0, KIND_DATA, KIND_DATA);
        add_row(CMD_SEND,      '0,       6'd0,  '0,       1'b0, 0, KIND_DATA, KIND_DATA);
        // reopen over a live window
        add_row(CMD_OPEN,      20'h80000, 6'd2, '0,       1'b1, 0, KIND_DATA, KIND_DATA);
        add_row(CMD_SEND,      '0,       6'd0,  '0,       1'b0, 0, KIND_DATA, KIND_DATA);
        add_row(CMD_MISSING,   '0,       6'd0,  20'h80003, 1'b1, 1, KIND_ABORT, KIND_DATA);
        // empty window, then timeouts past the reset limit
        add_row(CMD_OPEN,      SEQ_MAX,  6'd0,  '0,       1'b1, 0, KIND_DATA, KIND_DATA);
        add_row(CMD_SEND,      '0,       6'd0,  '0,       1'b1, 1, KIND_FIN, KIND_DATA);
        repeat (5)
            add_row(CMD_TIMEOUT, '0,     6'd0,  '0,       1'b1, 1, KIND_FIN, KIND_DATA);
        add_row(CMD_TIMEOUT,   '0,       6'd0,  '0,       1'b1, 2, KIND_FIN, KIND_DONE);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_limit_reg(RETRY_LIMIT_RESET);

        foreach (steps[i])
        begin
            run_request(steps[i].cmd, steps[i].ws, steps[i].wl, steps[i].ms, !steps[i].typed);
            if (steps[i].n_emits > 0)
            begin
                typed_emit      = make_emit(steps[i].k0, '0);
                typed_emit.last = (steps[i].n_emits == 1);
                expected_emits.insert(expected_emits.size(), typed_emit);
            end
            if (steps[i].n_emits > 1)
            begin
                typed_emit      = make_emit(steps[i].k1, '0);
                typed_emit.last = 1'b1;
                expected_emits.insert(expected_emits.size(), typed_emit);
            end
        end

        run_phase(0, 0, 24);
        run_phase(255, 85, 24);
        run_phase($urandom_range(6, 1), 31, 24);
        run_phase(2, 0, 24);

        drain();
        if (mismatch_count == 0)
            $display("tb_nak_window_retransmit_sender: clean");
        else
            $display("tb_nak_window_retransmit_sender: errors");
        $finish;
    end

endmodule

// File: filelist.f
src/nwrs_pkg.sv
src/nwrs_datapath.sv
src/nwrs_ctrl.sv
src/nak_window_retransmit_sender.sv
src/nwrs_checker.sv
bench/tb_nak_window_retransmit_sender.sv
